// File: design/wbd_pkg.sv
package wbd_pkg;

    localparam int MAX_BUFFER_WORDS_DEF = 32768;
    localparam int NUM_BLOCKS_DEF       = 2048;

    localparam int WORD_W     = 16;
    localparam int LEN_W      = 16;
    localparam int ID_W       = 11;
    localparam int IDX_W      = 15;
    localparam int STATUS_W   = 3;
    localparam int EPOCH_W    = 16;
    localparam int ADDR_W_MAX = 12;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 4;

    localparam logic signed [WORD_W-1:0] ID_ALIAS_A     = 16'sd2000;
    localparam logic signed [WORD_W-1:0] ID_ALIAS_A_MAP = 16'sd1080;
    localparam logic signed [WORD_W-1:0] ID_ALIAS_B     = 16'sd2001;
    localparam logic signed [WORD_W-1:0] ID_ALIAS_B_MAP = 16'sd1081;

    typedef enum logic [STATUS_W-1:0] {
        STS_HEADER   = 3'd0,
        STS_SAMPLE   = 3'd1,
        STS_DONE     = 3'd2,
        STS_TOO_LONG = 3'd3,
        STS_TRUNC    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_ID      = 4'b0001,
        PH_COUNT   = 4'b0010,
        PH_SAMPLES = 4'b0100,
        PH_SWALLOW = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        CS_CLEAR = 2'b01,
        CS_RUN   = 2'b10
    } t_clr_state;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W_MAX-1:0] rd_addr;
        logic                  wr_en;
        logic [ADDR_W_MAX-1:0] wr_addr;
        logic                  new_buf;
        logic                  start_clear;
    } t_seen_req;

    typedef struct packed {
        logic busy;
        logic epoch_full;
        logic hit;
    } t_seen_rsp;

endpackage

// File: design/wbd_ram.sv
module wbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/wbd_seen.sv
module wbd_seen
    import wbd_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seen_req i_req,
    output t_seen_rsp o_rsp
);

    localparam int AW = $clog2(NUM_BLOCKS);

    t_clr_state         r_state, n_state;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [EPOCH_W-1:0] ram_wdata;
    logic [EPOCH_W-1:0] ram_rdata;

    // An entry is set for this buffer when it carries the live epoch mark.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_epoch    = r_epoch;
        unique case (r_state)
            CS_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NUM_BLOCKS - 1)) begin
                    n_state = CS_RUN;
                    n_epoch = '0;
                end
            end
            CS_RUN: begin
                if (i_req.start_clear) begin
                    n_state    = CS_CLEAR;
                    n_clr_addr = '0;
                end else if (i_req.new_buf) begin
                    n_epoch = r_epoch + 1'b1;
                end
            end
            default: begin
                n_state    = CS_CLEAR;
                n_clr_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CS_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_epoch    <= n_epoch;
        end
    end

    always_comb begin
        if (r_state == CS_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = i_req.wr_en;
            ram_waddr = i_req.wr_addr[AW-1:0];
            ram_wdata = r_epoch;
        end
    end

    wbd_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_req.rd_en),
        .i_raddr (i_req.rd_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.busy       = (r_state == CS_CLEAR);
    assign o_rsp.epoch_full = &r_epoch;
    assign o_rsp.hit        = (ram_rdata == r_epoch);

endmodule

// File: design/wbd_core.sv
module wbd_core
    import wbd_pkg::*;
#(
    parameter int MAX_BUFFER_WORDS = MAX_BUFFER_WORDS_DEF,
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [WORD_W-1:0] i_word_value,
    input  logic                     i_buffer_start,
    input  logic [LEN_W-1:0]         i_buffer_length,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_status                  o_status,
    output logic [ID_W-1:0]          o_blk_id,
    output logic signed [WORD_W-1:0] o_sample_value,
    output logic [IDX_W-1:0]         o_sample_index,
    output logic                     o_last_sample,
    output logic                     o_buffer_done,
    output t_seen_req                o_seen_req,
    input  t_seen_rsp                i_seen_rsp
);

    localparam int AW = $clog2(NUM_BLOCKS);

    // input register
    logic                     r_in_valid;
    logic signed [WORD_W-1:0] r_in_word;
    logic                     r_in_bs;
    logic [LEN_W-1:0]         r_in_len;

    // parse state
    t_phase              r_phase, n_phase;
    logic [LEN_W-1:0]    r_words_left, n_words_left;
    logic [WORD_W-1:0]   r_samples_left, n_samples_left;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [AW-1:0]       r_blk, n_blk;
    logic                r_id_ok, n_id_ok;
    logic                r_acc, n_acc;

    // result register
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [ID_W-1:0]          r_out_block;
    logic signed [WORD_W-1:0] r_out_value;
    logic [IDX_W-1:0]         r_out_index;
    logic                     r_out_last;
    logic                     r_out_done;

    logic                     out_free;
    logic                     fire;
    logic                     in_ready;

    logic                     emit;
    t_status                  e_status;
    logic [ID_W-1:0]          e_blk;
    logic signed [WORD_W-1:0] e_val;
    logic [IDX_W-1:0]         e_idx;
    logic                     e_last;
    logic                     e_done;
    logic                     rd_en, wr_en;
    logic [ADDR_W_MAX-1:0]    rd_addr, wr_addr;

    assign out_free = !r_out_valid || i_ready;
    assign fire     = r_in_valid && !i_seen_rsp.busy
                      && !(r_in_bs && i_seen_rsp.epoch_full) && out_free;
    assign in_ready = !r_in_valid || fire;

    always_comb begin
        logic              live;
        logic [LEN_W-1:0]  rem;
        logic signed [WORD_W-1:0] id;
        logic              acc;
        t_phase            ph;

        n_phase        = r_phase;
        n_words_left   = r_words_left;
        n_samples_left = r_samples_left;
        n_pos          = r_pos;
        n_blk          = r_blk;
        n_id_ok        = r_id_ok;
        n_acc          = r_acc;
        emit     = 1'b0;
        e_status = STS_DONE;
        e_blk    = '0;
        e_val    = '0;
        e_idx    = '0;
        e_last   = 1'b0;
        e_done   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        live     = 1'b1;
        rem      = '0;
        id       = r_in_word;
        acc      = r_id_ok && !i_seen_rsp.hit;

        // a buffer start wipes the parse state before the word is looked at
        if (r_in_bs) begin
            n_samples_left = '0;
            n_pos          = '0;
            n_blk          = '0;
            n_id_ok        = 1'b0;
            n_acc          = 1'b0;
            n_words_left   = '0;
            if ({1'b0, r_in_len} > (LEN_W + 1)'(MAX_BUFFER_WORDS)) begin
                n_phase  = PH_SWALLOW;
                emit     = 1'b1;
                e_status = STS_TOO_LONG;
                e_done   = 1'b1;
                live     = 1'b0;
            end else if (r_in_len == '0) begin
                n_phase  = PH_SWALLOW;
                emit     = 1'b1;
                e_status = STS_DONE;
                e_done   = 1'b1;
                live     = 1'b0;
            end else begin
                n_phase      = PH_ID;
                n_words_left = r_in_len;
            end
        end

        ph = n_phase;
        if (live && ph != PH_SWALLOW && n_words_left != '0) begin
            rem          = n_words_left - 1'b1;
            n_words_left = rem;
            unique case (ph)
                PH_ID: begin
                    if (rem == '0) begin
                        n_phase  = PH_SWALLOW;
                        emit     = 1'b1;
                        e_status = STS_TRUNC;
                        e_done   = 1'b1;
                    end else begin
                        if (r_in_word == ID_ALIAS_A) begin
                            id = ID_ALIAS_A_MAP;
                        end else if (r_in_word == ID_ALIAS_B) begin
                            id = ID_ALIAS_B_MAP;
                        end
                        if (!id[WORD_W-1] && ($unsigned(id) < WORD_W'(NUM_BLOCKS))) begin
                            n_blk   = id[AW-1:0];
                            n_id_ok = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = ADDR_W_MAX'(id[AW-1:0]);
                        end else begin
                            n_blk   = '0;
                            n_id_ok = 1'b0;
                        end
                        n_phase = PH_COUNT;
                    end
                end
                PH_COUNT: begin
                    if (r_in_word[WORD_W-1] || ({1'b0, r_in_word[WORD_W-2:0]} > rem)) begin
                        n_phase      = PH_SWALLOW;
                        n_words_left = '0;
                        emit         = 1'b1;
                        e_status     = STS_TRUNC;
                        e_done       = 1'b1;
                    end else begin
                        n_samples_left = r_in_word;
                        n_pos          = '0;
                        n_phase        = (r_in_word != '0) ? PH_SAMPLES : PH_ID;
                        if (rem == '0) begin
                            n_phase = PH_SWALLOW;
                        end
                        n_acc = acc;
                        if (acc) begin
                            wr_en    = 1'b1;
                            wr_addr  = ADDR_W_MAX'(r_blk);
                            emit     = 1'b1;
                            e_status = STS_HEADER;
                            e_blk    = ID_W'(r_blk);
                            e_done   = (rem == '0);
                        end else if (rem == '0) begin
                            emit     = 1'b1;
                            e_status = STS_DONE;
                            e_done   = 1'b1;
                        end
                    end
                end
                PH_SAMPLES: begin
                    if (r_samples_left != '0) begin
                        n_samples_left = r_samples_left - 1'b1;
                    end
                    n_pos = r_pos + 1'b1;
                    if (n_samples_left == '0) begin
                        n_phase = PH_ID;
                    end
                    if (rem == '0) begin
                        n_phase = PH_SWALLOW;
                    end
                    if (r_acc) begin
                        emit     = 1'b1;
                        e_status = STS_SAMPLE;
                        e_blk    = ID_W'(r_blk);
                        e_val    = r_in_word;
                        e_idx    = r_pos;
                        e_last   = (n_samples_left == '0);
                        e_done   = (rem == '0);
                    end else if (rem == '0) begin
                        emit     = 1'b1;
                        e_status = STS_DONE;
                        e_done   = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_SWALLOW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_ID;
            r_words_left   <= '0;
            r_samples_left <= '0;
            r_pos          <= '0;
            r_blk          <= '0;
            r_id_ok        <= 1'b0;
            r_acc          <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_out_valid    <= emit;
                r_phase        <= n_phase;
                r_words_left   <= n_words_left;
                r_samples_left <= n_samples_left;
                r_pos          <= n_pos;
                r_blk          <= n_blk;
                r_id_ok        <= n_id_ok;
                r_acc          <= n_acc;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_word <= i_word_value;
            r_in_bs   <= i_buffer_start;
            r_in_len  <= i_buffer_length;
        end
        if (fire && emit) begin
            r_out_status <= e_status;
            r_out_block  <= e_blk;
            r_out_value  <= e_val;
            r_out_index  <= e_idx;
            r_out_last   <= e_last;
            r_out_done   <= e_done;
        end
    end

    assign o_seen_req.rd_en       = fire && rd_en;
    assign o_seen_req.rd_addr     = rd_addr;
    assign o_seen_req.wr_en       = fire && wr_en;
    assign o_seen_req.wr_addr     = wr_addr;
    assign o_seen_req.new_buf     = fire && r_in_bs;
    assign o_seen_req.start_clear = r_in_valid && r_in_bs && i_seen_rsp.epoch_full
                                    && !i_seen_rsp.busy;

    assign o_ready        = in_ready;
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_blk_id       = r_out_block;
    assign o_sample_value = r_out_value;
    assign o_sample_index = r_out_index;
    assign o_last_sample  = r_out_last;
    assign o_buffer_done  = r_out_done;

endmodule

// File: design/waveform_block_deframer_top.sv
// Waveform block deframer.
// Input stream: one buffer word per beat. tdata carries the word and, on the
// first word of a buffer (tuser high), the buffer length in words. A buffer is
// a run of records: block id, sample count, then that many samples.
// Output stream: at most one result per input beat - a block header, a sample
// with its index and last-sample flag, or a buffer status (done, too long,
// truncated). tlast marks the result that ends a buffer.
// Path: each input beat is held in the input register, its result then in the
// result register. Throughput: one beat per cycle unless a sweep or tready stalls.
// The seen map sits in a RAM holding a buffer epoch per block id; the id is
// looked up while its word sits in the input register and the answer is used
// on the count word that follows.
// Reset: clears the parse state, then sweeps every entry of the seen RAM; the
// first beat waits in the input register, with tready low, until the sweep
// ends. The same sweep runs again once every 65535 buffers, when the epoch
// mark wraps, before that buffer's first word is taken.
// Stall: while the receiver holds tready low the result register holds; at
// most one more input beat is taken into the input register, then tready drops.
module waveform_block_deframer_top
    import wbd_pkg::*;
#(
    parameter int MAX_BUFFER_WORDS = MAX_BUFFER_WORDS_DEF,
    parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [15:0] word_value, [31:16] buffer_length
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] buffer_start
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [10:0] blk_id, [26:11] sample_value, [41:27] sample_index, [47:42] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] status, [3] last_sample
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,
    // buffer_done
    output logic                 o_m_axis_tlast
);

    t_seen_req                seen_req;
    t_seen_rsp                seen_rsp;
    t_status                  status;
    logic [ID_W-1:0]          blk_id;
    logic signed [WORD_W-1:0] sample_value;
    logic [IDX_W-1:0]         sample_index;
    logic                     last_sample;

    wbd_core #(
        .MAX_BUFFER_WORDS (MAX_BUFFER_WORDS),
        .NUM_BLOCKS       (NUM_BLOCKS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_word_value    (i_s_axis_tdata[WORD_W-1:0]),
        .i_buffer_start  (i_s_axis_tuser[0]),
        .i_buffer_length (i_s_axis_tdata[WORD_W+LEN_W-1:WORD_W]),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_status        (status),
        .o_blk_id        (blk_id),
        .o_sample_value  (sample_value),
        .o_sample_index  (sample_index),
        .o_last_sample   (last_sample),
        .o_buffer_done   (o_m_axis_tlast),
        .o_seen_req      (seen_req),
        .i_seen_rsp      (seen_rsp)
    );

    wbd_seen #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_seen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seen_req),
        .o_rsp   (seen_rsp)
    );

    assign o_m_axis_tdata = {
        (M_TDATA_W - ID_W - WORD_W - IDX_W)'(0),
        sample_index,
        sample_value,
        blk_id
    };
    assign o_m_axis_tuser = {last_sample, status};

endmodule

// File: design/wbd_checker.sv
module wbd_checker
    import wbd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input logic [S_TUSER_W-1:0] i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser,
    input logic                 o_m_axis_tlast
);

    // nothing comes out of the block straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // only a sample carries value, index and last flag
    a_sample_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[2:0] != STS_SAMPLE) |->
            (o_m_axis_tdata[41:11] == '0) && !o_m_axis_tuser[3])
        else $error("non-sample result carries sample fields");

    // a buffer status always ends the buffer and names no block
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ((o_m_axis_tuser[2:0] == STS_DONE)
            || (o_m_axis_tuser[2:0] == STS_TOO_LONG)
            || (o_m_axis_tuser[2:0] == STS_TRUNC)) |->
            o_m_axis_tlast && (o_m_axis_tdata[10:0] == '0))
        else $error("buffer status without buffer end");

endmodule

bind waveform_block_deframer_top wbd_checker u_wbd_checker (.*);

// File: tb/waveform_block_deframer_top_tb.sv
module waveform_block_deframer_top_tb;
    import wbd_pkg::*;

    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_BEATS = 1400;
    localparam int LIMIT        = 10_000_000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
        logic [LEN_W-1:0]  len;
    } t_beat;

    typedef struct {
        t_status                  status;
        logic [ID_W-1:0]          blk;
        logic signed [WORD_W-1:0] val;
        logic [IDX_W-1:0]         idx;
        logic                     last;
        logic                     done;
    } t_deframe_result;

    class t_deframe_scoreboard;
        t_deframe_result          expected_q[$];
        int                       errors;
        t_phase                   phase;
        logic [LEN_W-1:0]         words_left;
        logic [LEN_W-1:0]         samples_left;
        logic [IDX_W-1:0]         sample_pos;
        logic [ID_W-1:0]          cur_blk;
        logic                     cur_accepted;
        bit                       seen_map [NUM_BLOCKS_DEF];

        function new();
            errors = 0;
            phase = PH_ID;
            words_left = '0;
            samples_left = '0;
            sample_pos = '0;
            cur_blk = '0;
            cur_accepted = 1'b0;
            foreach (seen_map[i]) seen_map[i] = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push(t_status st, logic [ID_W-1:0] blk, logic signed [WORD_W-1:0] val,
                           logic [IDX_W-1:0] idx, logic last, logic done);
            t_deframe_result r;
            r.status = st;
            r.blk = blk;
            r.val = val;
            r.idx = idx;
            r.last = last;
            r.done = done;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Advance the parser by one accepted input beat.
        function void note_beat(logic signed [WORD_W-1:0] w, logic start, logic [LEN_W-1:0] len);
            logic [LEN_W-1:0]         rem;
            logic signed [WORD_W-1:0] id;
            logic [IDX_W-1:0]         idx;
            logic                     last;
            if (start) begin
                foreach (seen_map[i]) seen_map[i] = 1'b0;
                samples_left = '0;
                sample_pos = '0;
                cur_blk = '0;
                cur_accepted = 1'b0;
                words_left = '0;
                if (len > MAX_BUFFER_WORDS_DEF) begin
                    phase = PH_SWALLOW;
                    push(STS_TOO_LONG, '0, '0, '0, 1'b0, 1'b1);
                    return;
                end
                if (len == 0) begin
                    phase = PH_SWALLOW;
                    push(STS_DONE, '0, '0, '0, 1'b0, 1'b1);
                    return;
                end
                phase = PH_ID;
                words_left = len;
            end
            if (phase == PH_SWALLOW || words_left == 0)
                return;
            words_left = words_left - 1'b1;
            rem = words_left;
            case (phase)
                PH_ID: begin
                    if (rem == 0) begin
                        phase = PH_SWALLOW;
                        push(STS_TRUNC, '0, '0, '0, 1'b0, 1'b1);
                        return;
                    end
                    id = w;
                    if (id == ID_ALIAS_A)
                        id = ID_ALIAS_A_MAP;
                    else if (id == ID_ALIAS_B)
                        id = ID_ALIAS_B_MAP;
                    if (id >= 0 && id < NUM_BLOCKS_DEF) begin
                        cur_blk = id[ID_W-1:0];
                        cur_accepted = !seen_map[id[ID_W-1:0]];
                    end else begin
                        cur_blk = '0;
                        cur_accepted = 1'b0;
                    end
                    phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (w < 0 || $unsigned(w) > rem) begin
                        phase = PH_SWALLOW;
                        words_left = '0;
                        push(STS_TRUNC, '0, '0, '0, 1'b0, 1'b1);
                        return;
                    end
                    samples_left = w;
                    sample_pos = '0;
                    if (samples_left != 0)
                        phase = PH_SAMPLES;
                    else
                        phase = PH_ID;
                    if (rem == 0)
                        phase = PH_SWALLOW;
                    if (cur_accepted) begin
                        seen_map[cur_blk] = 1'b1;
                        push(STS_HEADER, cur_blk, '0, '0, 1'b0, rem == 0);
                    end else if (rem == 0) begin
                        push(STS_DONE, '0, '0, '0, 1'b0, 1'b1);
                    end
                end
                default: begin
                    idx = sample_pos;
                    if (samples_left > 0)
                        samples_left = samples_left - 1'b1;
                    last = (samples_left == 0);
                    sample_pos = sample_pos + 1'b1;
                    if (last)
                        phase = PH_ID;
                    if (rem == 0)
                        phase = PH_SWALLOW;
                    if (cur_accepted)
                        push(STS_SAMPLE, cur_blk, w, idx, last, rem == 0);
                    else if (rem == 0)
                        push(STS_DONE, '0, '0, '0, 1'b0, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
                                 logic tlast);
            t_deframe_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tuser %0h tdata %0h",
                         $time, tuser, tdata);
                return;
            end
            want = expected_q.pop_front();
            check_field("status", 32'(want.status), 32'(tuser[2:0]));
            check_field("blk_id", 32'(want.blk), 32'(tdata[10:0]));
            check_field("sample_value", 32'(unsigned'(want.val)), 32'(tdata[26:11]));
            check_field("sample_index", 32'(want.idx), 32'(tdata[41:27]));
            check_field("last_sample", 32'(want.last), 32'(tuser[3]));
            check_field("buffer_done", 32'(want.done), 32'(tlast));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // [15:0] word_value, [31:16] buffer_length
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    // [0] buffer_start
    logic [S_TUSER_W-1:0] i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // [10:0] blk_id, [26:11] sample_value, [41:27] sample_index, [47:42] zero
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    // [2:0] status, [3] last_sample
    logic [M_TUSER_W-1:0] o_m_axis_tuser;
    // buffer_done
    logic                 o_m_axis_tlast;

    t_deframe_scoreboard sb;
    t_beat               beat_q[$];
    int                  beats_sent;
    bit                  sender_steady;
    bit                  hold_req;
    bit                  hold_done;

    waveform_block_deframer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_beat(logic [WORD_W-1:0] w, logic s, logic [LEN_W-1:0] n);
        t_beat b;
        b.word = w;
        b.start = s;
        b.len = n;
        beat_q.insert(beat_q.size(), b);
    endfunction

    task automatic send_beat(input t_beat b);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b.len, b.word};
        i_s_axis_tuser  <= b.start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_beat(b.word, b.start, b.len);
        beats_sent++;
    endtask

    task automatic flush_beats();
        while (beat_q.size() != 0)
            send_beat(beat_q.pop_front());
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One buffer of records, mostly well formed, sometimes damaged.
    task automatic build_buffer();
        logic [WORD_W-1:0] body[$];
        logic [WORD_W-1:0] id;
        int                nrec, cnt, r, len, nsend;
        nrec = $urandom_range(1, 6);
        repeat (nrec) begin
            r = $urandom_range(0, 99);
            if (r < 50)
                id = $urandom_range(0, 15);
            else if (r < 62) begin
                case ($urandom_range(0, 3))
                    0: id = ID_ALIAS_A;
                    1: id = ID_ALIAS_B;
                    2: id = ID_ALIAS_A_MAP;
                    default: id = ID_ALIAS_B_MAP;
                endcase
            end else if (r < 75)
                id = $urandom_range(0, NUM_BLOCKS_DEF - 1);
            else if (r < 85)
                id = $urandom_range(0, 1) ? NUM_BLOCKS_DEF - 1 : 0;
            else if (r < 93)
                id = $urandom_range(NUM_BLOCKS_DEF, 32767);
            else
                id = $urandom_range(32768, 65535);
            r = $urandom_range(0, 99);
            if (r < 15)
                cnt = 0;
            else if (r < 88)
                cnt = $urandom_range(1, 6);
            else
                cnt = $urandom_range(7, 40);
            body.insert(body.size(), id);
            body.insert(body.size(), WORD_W'(cnt));
            repeat (cnt) body.insert(body.size(), WORD_W'($urandom));
        end
        len = body.size();
        nsend = body.size();
        r = $urandom_range(0, 99);
        if (r < 70) begin
        end else if (r < 80) begin
            // cut short; words past the end are stray
            len = $urandom_range(1, body.size() - 1);
            nsend = len + $urandom_range(0, 2);
            if (nsend > body.size())
                nsend = body.size();
        end else if (r < 85) begin
            len = body.size() + $urandom_range(1, 5);
        end else if (r < 90) begin
            body[1] = $urandom_range(32768, 65535);
        end else if (r < 94) begin
            len = $urandom_range(MAX_BUFFER_WORDS_DEF + 1, 65535);
        end else if (r < 97) begin
            len = 0;
        end else begin
            body[1] = WORD_W'(body.size());
        end
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 2)) add_beat(WORD_W'($urandom), 1'b0, LEN_W'($urandom));
        for (int i = 0; i < nsend; i++)
            add_beat(body[i], i == 0, (i == 0) ? LEN_W'(len) : LEN_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_beat(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
    end

    // receiver: ready stretches, random gaps, and one long hold on request
    initial begin : receiver
        int gap;
        hold_done = 1'b0;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
                if ($urandom_range(0, 15) == 0)
                    repeat ($urandom_range(50, 150)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("waveform_block_deframer_top_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int nbuf;
        sb = new();
        beats_sent = 0;
        sender_steady = 1'b0;
        hold_req = 1'b0;
        i_rst_n <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        i_s_axis_tuser <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray word with no buffer open
        add_beat(16'h1234, 1'b0, 16'h0000);
        // empty buffer
        add_beat(16'h0000, 1'b1, 16'd0);
        // too long, then a swallowed word
        add_beat(16'hffff, 1'b1, 16'hffff);
        add_beat(16'h5555, 1'b0, 16'haaaa);
        // alias id with extreme samples
        add_beat(ID_ALIAS_A, 1'b1, 16'd4);
        add_beat(16'd2, 1'b0, 16'd0);
        add_beat(16'h8000, 1'b0, 16'd0);
        add_beat(16'h7fff, 1'b0, 16'd0);
        // both aliases, then a repeat of a seen id ending the buffer with a done status
        add_beat(ID_ALIAS_B, 1'b1, 16'd7);
        add_beat(16'd0, 1'b0, 16'd0);
        add_beat(ID_ALIAS_A, 1'b0, 16'd0);
        add_beat(16'd1, 1'b0, 16'd0);
        add_beat(16'd7, 1'b0, 16'd0);
        add_beat(ID_ALIAS_A_MAP, 1'b0, 16'd0);
        add_beat(16'd0, 1'b0, 16'd0);
        // a lone id word as the whole buffer, truncated
        add_beat(16'd5, 1'b1, 16'd1);
        // negative count
        add_beat(16'd3, 1'b1, 16'd4);
        add_beat(16'h8000, 1'b0, 16'd0);
        add_beat(16'd1, 1'b0, 16'd0);
        add_beat(16'd2, 1'b0, 16'd0);
        // count past the end
        add_beat(16'd3, 1'b1, 16'd4);
        add_beat(16'd3, 1'b0, 16'd0);
        add_beat(16'd1, 1'b0, 16'd0);
        add_beat(16'd2, 1'b0, 16'd0);
        // top id kept, first out-of-range id dropped
        add_beat(16'd2047, 1'b1, 16'd4);
        add_beat(16'd0, 1'b0, 16'd0);
        add_beat(16'd2048, 1'b0, 16'd0);
        add_beat(16'd0, 1'b0, 16'd0);
        // restart in the middle of a buffer
        add_beat(16'd4, 1'b1, 16'd6);
        add_beat(16'd3, 1'b0, 16'd0);
        add_beat(16'd0, 1'b1, 16'd3);
        add_beat(16'd1, 1'b0, 16'd0);
        add_beat(16'hffff, 1'b0, 16'd0);
        flush_beats();
        wait_drained();

        nbuf = 0;
        while (beats_sent < RANDOM_BEATS) begin
            nbuf++;
            sender_steady = ($urandom_range(0, 3) == 0);
            if (nbuf == 4) begin
                // fill the block while the receiver holds off
                hold_req = 1'b1;
                sender_steady = 1'b1;
            end
            build_buffer();
            flush_beats();
            if (nbuf % 15 == 0)
                wait_drained();
        end

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("waveform_block_deframer_top_tb: PASS");
        else
            $display("waveform_block_deframer_top_tb: FAIL");
        $finish;
    end

endmodule
